@@ hw/rtl/ipg_pkg.sv @@
// Shared constants, register codes and transaction types of the image pyramid gradient block
`default_nettype none

package ipg_pkg;

  // Field widths
  localparam int PIX_W      = 16;
  localparam int IDX_W      = 20;
  localparam int GRAD_W     = 17;
  localparam int SQ_W       = 33;
  localparam int LVL_W      = 3;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int LU_W       = 3;

  // Default sizes and result queue depth
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_LEVELS     = 6;
  localparam int QUEUE_DEPTH    = 4;

  // Register values after reset
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [LU_W-1:0]       RST_LEVELS_USED  = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_LEVELS_USED  = 2'd2
  } cfg_reg_t;

  // Pixel travelling up the chain of level cells
  typedef struct packed {
    logic             valid;
    logic             alive;
    logic             frame_start;
    logic [PIX_W-1:0] value;
  } pix_tok_t;

  // Gradient result of one level, before squaring
  typedef struct packed {
    logic [IDX_W-1:0]         pixel_index;
    logic [PIX_W-1:0]         intensity;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
  } grad_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/ipg_if.sv @@
// Stream interfaces for level-0 pixels in and gradient results out
`default_nettype none

interface ipg_pix_if;
  logic                      valid;
  logic                      ready;
  logic [ipg_pkg::PIX_W-1:0] pixel_value;
  logic                      frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface ipg_res_if;
  logic                              valid;
  logic                              ready;
  logic [ipg_pkg::LVL_W-1:0]         level;
  logic [ipg_pkg::IDX_W-1:0]         pixel_index;
  logic [ipg_pkg::PIX_W-1:0]         intensity;
  logic signed [ipg_pkg::GRAD_W-1:0] grad_x;
  logic signed [ipg_pkg::GRAD_W-1:0] grad_y;
  logic [ipg_pkg::SQ_W-1:0]          grad_sq;
  logic                              last;

  modport source (output valid, output level, output pixel_index, output intensity,
                  output grad_x, output grad_y, output grad_sq, output last, input ready);
  modport sink   (input valid, input level, input pixel_index, input intensity,
                  input grad_x, input grad_y, input grad_sq, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/image_pyramid_gradient.sv @@
// Path: a level-l result passes the cell chain, its delay line, the result queue and issue stages a,
//   b and c; it leaves later when the output side stalls.
// Throughput: one level-0 pixel per cycle while the queue has room, through a chain of one cell
//   per level, two stages each; results leave one per cycle unless stalled, so a burst of more
//   than one result per pixel fills a four-entry queue, then holds the input until it drains.
// Reset: counters, valid bits and registers (640, 480, 6) clear at once; line buffers hold
//   undefined data until written, with no clearing pass.
`default_nettype none

module image_pyramid_gradient #(
  parameter int MAX_WIDTH  = ipg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ipg_pkg::DEF_MAX_HEIGHT,
  parameter int LEVELS     = ipg_pkg::DEF_LEVELS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  ipg_pix_if.sink                                pix_in,
  ipg_res_if.source                              res_out,
  input  wire logic                              cfg_write,
  input  wire logic [ipg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ipg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int NLW = $clog2(LEVELS + 1);

  logic [ipg_pkg::CFG_DATA_W-1:0] frame_width;
  logic [ipg_pkg::CFG_DATA_W-1:0] frame_height;
  logic [ipg_pkg::LU_W-1:0]       levels_used;

  logic [DW-1:0]  ew;
  logic [HW-1:0]  eh;
  logic [NLW-1:0] nlev;
  logic           adv;
  logic           full;
  logic           push;

  ipg_pkg::pix_tok_t               tok [LEVELS+1];
  logic [LEVELS-1:0]               res_v;
  ipg_pkg::grad_res_t [LEVELS-1:0] res_all;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ipg_pkg::RST_FRAME_WIDTH;
      frame_height <= ipg_pkg::RST_FRAME_HEIGHT;
      levels_used  <= ipg_pkg::RST_LEVELS_USED;
    end else if (cfg_write) begin
      case (ipg_pkg::cfg_reg_t'(cfg_index))
        ipg_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        ipg_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        ipg_pkg::REG_LEVELS_USED:  levels_used  <= cfg_data[ipg_pkg::LU_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes and level count
  always_comb begin
    ew = (32'(frame_width) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(frame_width);
    eh = (32'(frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height);
    if (levels_used == '0) begin
      nlev = NLW'(1);
    end else if (32'(levels_used) > LEVELS) begin
      nlev = NLW'(LEVELS);
    end else begin
      nlev = NLW'(levels_used);
    end
  end

  // Whole chain steps while the queue has room
  assign adv          = !full;
  assign pix_in.ready = adv;

  always_comb begin
    tok[0].valid       = pix_in.valid && adv;
    tok[0].alive       = 1'b1;
    tok[0].frame_start = pix_in.frame_start;
    tok[0].value       = pix_in.pixel_value;
  end

  generate
    for (genvar l = 0; l < LEVELS; l++) begin : g_cell
      ipg_cell #(
        .MAX_WIDTH (MAX_WIDTH),
        .LEVELS    (LEVELS),
        .LEVEL     (l),
        .DW        (DW),
        .HW        (HW),
        .NLW       (NLW)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .adv       (adv),
        .nlev      (nlev),
        .ew        (ew),
        .eh        (eh),
        .tok_in    (tok[l]),
        .tok_out   (tok[l+1]),
        .res_valid (res_v[l]),
        .res       (res_all[l])
      );
    end
  endgenerate

  // Queue the aligned result set of one pixel
  assign push = adv && tok[LEVELS].valid && (res_v != '0);

  ipg_result_queue #(
    .LEVELS (LEVELS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_mask (res_v),
    .push_res  (res_all),
    .full      (full),
    .res_out   (res_out)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ipg_cell.sv @@
// One pyramid level: line buffers, position counters, gradients and 2x2 averaging
`default_nettype none

module ipg_cell #(
  parameter int MAX_WIDTH = ipg_pkg::DEF_MAX_WIDTH,
  parameter int LEVELS    = ipg_pkg::DEF_LEVELS,
  parameter int LEVEL     = 0,
  parameter int DW        = 11,
  parameter int HW        = 11,
  parameter int NLW       = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              adv,
  input  wire logic [NLW-1:0]                    nlev,
  input  wire logic [DW-1:0]                     ew,
  input  wire logic [HW-1:0]                     eh,
  input  wire ipg_pkg::pix_tok_t                 tok_in,
  output ipg_pkg::pix_tok_t                      tok_out,
  output logic                                   res_valid,
  output ipg_pkg::grad_res_t                     res
);

  localparam int LD_RAW    = MAX_WIDTH >> LEVEL;
  localparam int LD        = (LD_RAW < 1) ? 1 : LD_RAW;
  localparam int AW        = (LD > 1) ? $clog2(LD) : 1;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int DLY       = 2 * (LEVELS - 1 - LEVEL);

  // Line buffers: one row back and two rows back
  logic [ipg_pkg::PIX_W-1:0] line1 [MEM_DEPTH];
  logic [ipg_pkg::PIX_W-1:0] line2 [MEM_DEPTH];

  logic [DW-1:0]             col;
  logic [HW-1:0]             row;
  logic [ipg_pkg::IDX_W-1:0] pcount;

  logic [DW-1:0]             w;
  logic [HW-1:0]             h;
  logic [DW-1:0]             col_c;
  logic [HW-1:0]             row_c;
  logic [ipg_pkg::IDX_W-1:0] p_c;
  logic [DW-1:0]             col_inc;
  logic [DW-1:0]             col_nb;
  logic                      act;
  logic                      up_ok;
  logic                      take;
  logic [AW-1:0]             addr;
  logic [AW-1:0]             addr_nb;

  // Stage one registers
  logic                      valid1;
  logic                      take1;
  logic                      fs1;
  logic [ipg_pkg::PIX_W-1:0] v1;
  logic [DW-1:0]             col1;
  logic [HW-1:0]             row1;
  logic [ipg_pkg::IDX_W-1:0] p1;
  logic                      wone1;
  logic [ipg_pkg::PIX_W-1:0] q_mid;
  logic [ipg_pkg::PIX_W-1:0] q_next;
  logic [ipg_pkg::PIX_W-1:0] q_far;
  logic [ipg_pkg::PIX_W-1:0] prev_pix;
  logic [ipg_pkg::PIX_W-1:0] prev_mid;

  logic [ipg_pkg::PIX_W-1:0]         pn;
  logic signed [ipg_pkg::GRAD_W-1:0] gx;
  logic signed [ipg_pkg::GRAD_W-1:0] gy;
  logic [ipg_pkg::PIX_W+1:0]         blk_sum;
  logic                              made;
  logic                              rv2;
  ipg_pkg::grad_res_t                r2;

  // Level geometry and position of the arriving pixel
  always_comb begin
    w       = ew >> LEVEL;
    h       = eh >> LEVEL;
    col_c   = tok_in.frame_start ? '0 : col;
    row_c   = tok_in.frame_start ? '0 : row;
    p_c     = tok_in.frame_start ? '0 : pcount;
    act     = 32'(nlev) > LEVEL;
    up_ok   = 32'(nlev) > (LEVEL + 1);
    take    = tok_in.valid && tok_in.alive && act && (w != '0) && (h != '0) &&
              (row_c < h) && (col_c < w);
    col_inc = col_c + 1'b1;
    col_nb  = (col_inc == w) ? '0 : col_inc;
    addr    = col_c[AW-1:0];
    addr_nb = col_nb[AW-1:0];
  end

  // Advance position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      pcount <= '0;
    end else if (adv && tok_in.valid) begin
      if (take) begin
        pcount <= p_c + 1'b1;
        if (col_inc >= w) begin
          col <= '0;
          row <= row_c + 1'b1;
        end else begin
          col <= col_inc;
          row <= row_c;
        end
      end else begin
        col    <= col_c;
        row    <= row_c;
        pcount <= p_c;
      end
    end
  end

  // Write the pixel and read the row above, read-first
  always_ff @(posedge clk) begin
    if (adv) begin
      if (take) begin
        line1[addr] <= tok_in.value;
      end
      q_mid  <= line1[addr];
      q_next <= line1[addr_nb];
      if (take1 && (col1[AW-1:0] == addr)) begin
        q_far <= q_mid;
      end else begin
        q_far <= line2[addr];
      end
      if (take1) begin
        line2[col1[AW-1:0]] <= q_mid;
      end
    end
  end

  // Stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      take1  <= 1'b0;
    end else if (adv) begin
      valid1 <= tok_in.valid;
      take1  <= take;
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (adv) begin
      fs1   <= tok_in.frame_start;
      v1    <= tok_in.value;
      col1  <= col_c;
      row1  <= row_c;
      p1    <= p_c;
      wone1 <= (w == DW'(1));
      if (take1) begin
        prev_pix <= v1;
        prev_mid <= q_mid;
      end
    end
  end

  // Gradients and the 2x2 block average
  always_comb begin
    pn      = wone1 ? v1 : q_next;
    gx      = $signed({1'b0, pn}) - $signed({1'b0, prev_mid});
    gy      = $signed({1'b0, v1}) - $signed({1'b0, q_far});
    blk_sum = {2'b00, prev_mid} + {2'b00, q_mid} + {2'b00, prev_pix} + {2'b00, v1};
    made    = take1 && up_ok && col1[0] && row1[0] &&
              (col1 < {w[DW-1:1], 1'b0}) && (row1 < {h[HW-1:1], 1'b0});
  end

  // Output registers: token to the next level and this level's result
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      tok_out.alive <= 1'b0;
      rv2           <= 1'b0;
    end else if (adv) begin
      tok_out.valid <= valid1;
      tok_out.alive <= made;
      rv2           <= take1 && (row1 > HW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_out.frame_start <= fs1;
      tok_out.value       <= blk_sum[ipg_pkg::PIX_W+1:2];
      r2.pixel_index      <= p1 - ipg_pkg::IDX_W'(w);
      r2.intensity        <= q_mid;
      r2.grad_x           <= gx;
      r2.grad_y           <= gy;
    end
  end

  // Delay the result so that all levels line up at the end of the chain
  generate
    if (DLY == 0) begin : g_nodly
      assign res_valid = rv2;
      assign res       = r2;
    end else begin : g_dly
      logic [DLY-1:0]     dv;
      ipg_pkg::grad_res_t dr [DLY];

      always_ff @(posedge clk) begin
        if (rst) begin
          dv <= '0;
        end else if (adv) begin
          dv <= {dv[DLY-2:0], rv2};
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          dr[0] <= r2;
          for (int k = 1; k < DLY; k++) begin
            dr[k] <= dr[k-1];
          end
        end
      end

      assign res_valid = dv[DLY-1];
      assign res       = dr[DLY-1];
    end
  endgenerate

endmodule

`default_nettype wire

@@ hw/rtl/ipg_result_queue.sv @@
// Result queue: holds per-pixel result sets and issues them one by one with squared magnitude
`default_nettype none

module ipg_result_queue #(
  parameter int LEVELS = ipg_pkg::DEF_LEVELS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  input  wire logic [LEVELS-1:0]                   push_mask,
  input  wire ipg_pkg::grad_res_t [LEVELS-1:0]     push_res,
  output logic                                     full,
  ipg_res_if.source                                res_out
);

  localparam int QAW = $clog2(ipg_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(ipg_pkg::QUEUE_DEPTH + 1);
  localparam int LSW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [LEVELS-1:0]                mask_q [ipg_pkg::QUEUE_DEPTH];
  ipg_pkg::grad_res_t [LEVELS-1:0]  data_q [ipg_pkg::QUEUE_DEPTH];
  logic [QAW-1:0]                   wr_ptr;
  logic [QAW-1:0]                   rd_ptr;
  logic [QCW-1:0]                   count;

  logic [LEVELS-1:0] head_mask;
  logic [LEVELS-1:0] rem;
  logic [LSW-1:0]    sel;
  logic              found;
  logic              take_a;
  logic              pop;
  logic              adv_a;
  logic              adv_b;
  logic              adv_c;

  // Stage registers
  logic                              va;
  logic [ipg_pkg::LVL_W-1:0]         lvl_a;
  ipg_pkg::grad_res_t                res_a;
  logic                              last_a;
  logic                              vb;
  logic [ipg_pkg::LVL_W-1:0]         lvl_b;
  ipg_pkg::grad_res_t                res_b;
  logic                              last_b;
  logic [ipg_pkg::SQ_W-2:0]          sqx_b;
  logic [ipg_pkg::SQ_W-2:0]          sqy_b;
  logic                              vc;
  logic signed [2*ipg_pkg::GRAD_W-1:0] px;
  logic signed [2*ipg_pkg::GRAD_W-1:0] py;

  // Pick the lowest pending level of the head entry
  always_comb begin
    head_mask = mask_q[rd_ptr];
    sel       = '0;
    found     = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if (!found && head_mask[i]) begin
        sel   = LSW'(i);
        found = 1'b1;
      end
    end
    rem    = head_mask & ~(LEVELS'(1) << sel);
    adv_c  = !vc || res_out.ready;
    adv_b  = !vb || adv_c;
    adv_a  = !va || adv_b;
    take_a = (count != '0) && adv_a;
    pop    = take_a && (rem == '0);
    full   = (count == QCW'(ipg_pkg::QUEUE_DEPTH));
    px     = res_a.grad_x * res_a.grad_x;
    py     = res_a.grad_y * res_a.grad_y;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mask_q[wr_ptr] <= push_mask;
      data_q[wr_ptr] <= push_res;
    end
    if (take_a) begin
      mask_q[rd_ptr] <= rem;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Issue pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (adv_a) begin
        va <= take_a;
      end
      if (adv_b) begin
        vb <= va;
      end
      if (adv_c) begin
        vc <= vb;
      end
    end
  end

  // Select, square, sum
  always_ff @(posedge clk) begin
    if (take_a) begin
      lvl_a  <= ipg_pkg::LVL_W'(sel);
      res_a  <= data_q[rd_ptr][sel];
      last_a <= (rem == '0);
    end
    if (adv_b) begin
      lvl_b  <= lvl_a;
      res_b  <= res_a;
      last_b <= last_a;
      sqx_b  <= px[ipg_pkg::SQ_W-2:0];
      sqy_b  <= py[ipg_pkg::SQ_W-2:0];
    end
    if (adv_c) begin
      res_out.level       <= lvl_b;
      res_out.pixel_index <= res_b.pixel_index;
      res_out.intensity   <= res_b.intensity;
      res_out.grad_x      <= res_b.grad_x;
      res_out.grad_y      <= res_b.grad_y;
      res_out.last        <= last_b;
      res_out.grad_sq     <= {1'b0, sqx_b} + {1'b0, sqy_b};
    end
  end

  assign res_out.valid = vc;

`ifndef SYNTH
  a_no_overflow : assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("result set pushed into a full queue");
  a_nonempty_set : assert property (@(posedge clk) disable iff (rst) push |-> (push_mask != '0))
    else $error("empty result set pushed");
  a_pop_count : assert property (@(posedge clk) disable iff (rst)
      (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count not reduced on pop");
`endif

endmodule

`default_nettype wire
